// ===== rtl/mpg_pkg.sv =====
// mpg_pkg: shared types, widths and constants of the mode pair grouping block
// used by mpg_ctrl, mpg_datapath and mode_pair_grouping; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package mpg_pkg;

  localparam int unsigned MODES         = 16;
  localparam int unsigned MAX_OCCUPANCY = 15;

  localparam int unsigned OCC_W  = 4;
  localparam int unsigned MODE_W = 4;
  localparam int unsigned DEG_W  = 4;
  localparam int unsigned KIND_W = 2;

  localparam int unsigned CTR_W  = $clog2(MODES);
  localparam int unsigned IDX_W  = $clog2(MODES);
  localparam int unsigned CNT_W  = $clog2(MODES + 1);
  localparam int unsigned WIDE_W = ((OCC_W > CNT_W) ? OCC_W : CNT_W) + 1;

  typedef enum logic [KIND_W-1:0] {
    KIND_SINGLE = 2'd0,
    KIND_PAIR   = 2'd1,
    KIND_MARKER = 2'd2
  } kind_e;

  typedef enum logic [0:0] {
    ST_IDLE  = 1'b0,
    ST_DRAIN = 1'b1
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE   = 3'd0,
    OP_ITEM   = 3'd1,
    OP_PAIR   = 3'd2,
    OP_EXTRA  = 3'd3,
    OP_SINGLE = 3'd4
  } op_e;

  typedef struct packed {
    op_e  op;
    logic done;
  } cmd_t;

  typedef struct packed {
    logic out_free;
    logic item_final;
    logic item_drain_empty;
    logic pair_left_nz;
    logic ext_left_nz;
    logic last_rec;
  } status_t;

endpackage

`default_nettype wire

// ===== rtl/mpg_ctrl.sv =====
// mpg_ctrl: controller state machine, sequences item intake and the final drain
// depends on mpg_pkg; drives mpg_datapath through cmd_t and reads status_t
`timescale 1ns / 1ps
`default_nettype none

module mpg_ctrl
  import mpg_pkg::*;
(
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    s_valid_i,
  input  status_t      status_i,
  output logic         s_ready_o,
  output cmd_t         cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o.op   = OP_NONE;
    cmd_o.done = 1'b0;
    s_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_ready_o = status_i.out_free;
        if (s_valid_i && status_i.out_free) begin
          cmd_o.op = OP_ITEM;
          if (status_i.item_final && !status_i.item_drain_empty) begin
            state_d = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (status_i.out_free) begin
          priority if (status_i.pair_left_nz) begin
            cmd_o.op = OP_PAIR;
          end else if (status_i.ext_left_nz) begin
            cmd_o.op = OP_EXTRA;
          end else begin
            cmd_o.op = OP_SINGLE;
          end
          cmd_o.done = status_i.last_rec;
          if (status_i.last_rec) begin
            state_d = ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== rtl/mpg_datapath.sv =====
// mpg_datapath: held mode, single store, drain counters and output register
// depends on mpg_pkg; commanded by mpg_ctrl
`timescale 1ns / 1ps
`default_nettype none

module mpg_datapath
  import mpg_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic [OCC_W-1:0]  occupancy_i,
  input  wire logic              is_final_i,
  input  wire logic              m_ready_i,
  input  cmd_t                   cmd_i,
  output status_t                status_o,
  output logic                   m_valid_o,
  output kind_e                  record_kind_o,
  output logic [MODE_W-1:0]      first_mode_o,
  output logic [MODE_W-1:0]      second_mode_o,
  output logic [DEG_W-1:0]       pair_degeneracy_o,
  output logic                   run_end_o
);

  logic [CTR_W-1:0]  ctr_q;
  logic              held_valid_q;
  logic [MODE_W-1:0] held_mode_q;
  logic [OCC_W-1:0]  held_rem_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [OCC_W-1:0]  pair_left_q;
  logic [CNT_W-1:0]  ext_q;
  logic [CNT_W-1:0]  sidx_q;
  logic [MODE_W-1:0] store_q [MODES];

  logic              ov_q;
  kind_e             kind_q;
  logic [MODE_W-1:0] first_q, second_q;
  logic [DEG_W-1:0]  deg_q;
  logic              last_q;

  // item evaluation
  logic [OCC_W-1:0]  occ_sat, d_val, rh, ro, hr_n, np;
  logic [MODE_W-1:0] idx, hm_n, push_mode;
  logic              fin, hv_n, push, do_push, pair;
  logic [CNT_W-1:0]  cnt_n, ext_n, cnt_m1;
  logic [WIDE_W-1:0] diff, remain;
  logic              drain_empty;
  logic [IDX_W-1:0]  rd_addr;
  logic [MODE_W-1:0] store_rd;
  logic              out_free, load;

  assign occ_sat = (occupancy_i > OCC_W'(MAX_OCCUPANCY)) ? OCC_W'(MAX_OCCUPANCY) : occupancy_i;
  assign idx     = MODE_W'(ctr_q);
  assign fin     = is_final_i || (ctr_q == CTR_W'(MODES - 1));
  assign d_val   = (held_rem_q <= occ_sat) ? held_rem_q : occ_sat;
  assign rh      = held_rem_q - d_val;
  assign ro      = occ_sat - d_val;

  always_comb begin
    hv_n      = held_valid_q;
    hm_n      = held_mode_q;
    hr_n      = held_rem_q;
    push      = 1'b0;
    push_mode = idx;
    pair      = 1'b0;
    if (occ_sat == OCC_W'(1)) begin
      push = 1'b1;
    end else if (occ_sat > OCC_W'(1)) begin
      if (!held_valid_q) begin
        hv_n = 1'b1;
        hm_n = idx;
        hr_n = occ_sat;
      end else begin
        pair = 1'b1;
        if (rh == '0 && ro == '0) begin
          hv_n = 1'b0;
          hr_n = '0;
        end else if (rh != '0) begin
          hr_n = rh;
          if (rh == OCC_W'(1)) begin
            push      = 1'b1;
            push_mode = held_mode_q;
            hv_n      = 1'b0;
            hr_n      = '0;
          end
        end else begin
          hm_n = idx;
          hr_n = ro;
          if (ro == OCC_W'(1)) begin
            push = 1'b1;
            hv_n = 1'b0;
            hr_n = '0;
          end
        end
      end
    end
  end

  assign do_push = push && (cnt_q < CNT_W'(MODES));
  assign cnt_n   = cnt_q + CNT_W'(do_push);

  // drain setup from the post-item state
  always_comb begin
    np    = '0;
    ext_n = '0;
    diff  = WIDE_W'(hr_n) - WIDE_W'(cnt_n);
    if (hv_n) begin
      if (WIDE_W'(hr_n) < WIDE_W'(cnt_n)) begin
        np = hr_n;
      end else begin
        np = OCC_W'(cnt_n);
        ext_n = (diff > WIDE_W'(MODES)) ? CNT_W'(MODES) : CNT_W'(diff);
      end
    end
  end

  assign drain_empty = (ext_n == '0) && (cnt_n == '0);

  assign cnt_m1   = cnt_q - CNT_W'(1);
  assign rd_addr  = (cmd_i.op == OP_PAIR) ? cnt_m1[IDX_W-1:0] : sidx_q[IDX_W-1:0];
  assign store_rd = store_q[rd_addr];
  assign remain   = WIDE_W'(ext_q) + WIDE_W'(cnt_q) - WIDE_W'(sidx_q);

  assign out_free = !ov_q || m_ready_i;
  assign load = ((cmd_i.op == OP_ITEM) && (pair || (fin && drain_empty))) ||
                (cmd_i.op == OP_PAIR) || (cmd_i.op == OP_EXTRA) || (cmd_i.op == OP_SINGLE);

  always_comb begin
    status_o.out_free         = out_free;
    status_o.item_final       = fin;
    status_o.item_drain_empty = drain_empty;
    status_o.pair_left_nz     = (pair_left_q != '0);
    status_o.ext_left_nz      = (ext_q != '0);
    status_o.last_rec         = (remain == WIDE_W'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctr_q        <= '0;
      held_valid_q <= 1'b0;
      held_mode_q  <= '0;
      held_rem_q   <= '0;
      cnt_q        <= '0;
      pair_left_q  <= '0;
      ext_q        <= '0;
      sidx_q       <= '0;
    end else begin
      unique case (cmd_i.op)
        OP_ITEM: begin
          cnt_q       <= cnt_n;
          held_mode_q <= hm_n;
          if (fin) begin
            ctr_q        <= '0;
            held_valid_q <= 1'b0;
            held_rem_q   <= '0;
            pair_left_q  <= np;
            ext_q        <= ext_n;
            sidx_q       <= '0;
          end else begin
            ctr_q        <= ctr_q + CTR_W'(1);
            held_valid_q <= hv_n;
            held_rem_q   <= hr_n;
          end
        end
        OP_PAIR: begin
          cnt_q       <= cnt_m1;
          pair_left_q <= pair_left_q - OCC_W'(1);
        end
        OP_EXTRA: begin
          ext_q <= ext_q - CNT_W'(1);
          if (cmd_i.done) begin
            cnt_q  <= '0;
            sidx_q <= '0;
          end
        end
        OP_SINGLE: begin
          if (cmd_i.done) begin
            cnt_q  <= '0;
            sidx_q <= '0;
          end else begin
            sidx_q <= sidx_q + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  // single store, no reset
  always_ff @(posedge clk_i) begin
    if ((cmd_i.op == OP_ITEM) && do_push) begin
      store_q[cnt_q[IDX_W-1:0]] <= push_mode;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else if (load) begin
      ov_q <= 1'b1;
    end else if (m_ready_i) begin
      ov_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      priority case (cmd_i.op)
        OP_ITEM: begin
          if (pair) begin
            kind_q   <= KIND_PAIR;
            first_q  <= held_mode_q;
            second_q <= idx;
            deg_q    <= DEG_W'(d_val);
          end else begin
            kind_q   <= KIND_MARKER;
            first_q  <= '0;
            second_q <= '0;
            deg_q    <= '0;
          end
          last_q <= fin && drain_empty;
        end
        OP_PAIR: begin
          kind_q   <= KIND_PAIR;
          first_q  <= held_mode_q;
          second_q <= store_rd;
          deg_q    <= DEG_W'(1);
          last_q   <= cmd_i.done;
        end
        OP_EXTRA: begin
          kind_q   <= KIND_SINGLE;
          first_q  <= held_mode_q;
          second_q <= '0;
          deg_q    <= DEG_W'(1);
          last_q   <= cmd_i.done;
        end
        default: begin
          kind_q   <= KIND_SINGLE;
          first_q  <= store_rd;
          second_q <= '0;
          deg_q    <= DEG_W'(1);
          last_q   <= cmd_i.done;
        end
      endcase
    end
  end

  assign m_valid_o         = ov_q;
  assign record_kind_o     = kind_q;
  assign first_mode_o      = first_q;
  assign second_mode_o     = second_q;
  assign pair_degeneracy_o = deg_q;
  assign run_end_o         = last_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MODES))
    else $error("single count beyond store depth");

  a_sidx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sidx_q <= cnt_q)
    else $error("single read pointer passed the count");

  a_held_rem: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_valid_q |-> (held_rem_q >= OCC_W'(2)))
    else $error("held mode with remainder below two");

  a_drain_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.done |=> (cnt_q == '0) && (sidx_q == '0) && (ext_q == '0) && (pair_left_q == '0))
    else $error("drain finished with work left");

endmodule

`default_nettype wire

// ===== rtl/mode_pair_grouping.sv =====
// mode_pair_grouping: top level, stream ports around mpg_ctrl and mpg_datapath
// depends on mpg_pkg, mpg_ctrl, mpg_datapath
// a record caused directly by a transaction is presented in the cycle after it;
//   drained records follow a final transaction one per cycle while the receiver keeps up
// throughput: one non-final item per cycle while the receiver keeps up; intake stops
//   during a drain; reset clears all but the single store and the output record fields
`timescale 1ns / 1ps
`default_nettype none

module mode_pair_grouping
  import mpg_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [7:0]  s_axis_tdata_i,   // [3:0] occupancy
  input  wire logic        s_axis_tlast_i,   // is_final
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [3:0] first_mode, [7:4] second_mode,
                                             // [11:8] pair_degeneracy
  output logic [1:0]       m_axis_tuser_o,   // [1:0] record_kind
  output logic             m_axis_tlast_o    // run_end
);

  cmd_t              cmd;
  status_t           status;
  kind_e             kind;
  logic [MODE_W-1:0] first_mode, second_mode;
  logic [DEG_W-1:0]  pair_degeneracy;

  mpg_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .status_i  (status),
    .s_ready_o (s_axis_tready_o),
    .cmd_o     (cmd)
  );

  mpg_datapath u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .occupancy_i       (s_axis_tdata_i[OCC_W-1:0]),
    .is_final_i        (s_axis_tlast_i),
    .m_ready_i         (m_axis_tready_i),
    .cmd_i             (cmd),
    .status_o          (status),
    .m_valid_o         (m_axis_tvalid_o),
    .record_kind_o     (kind),
    .first_mode_o      (first_mode),
    .second_mode_o     (second_mode),
    .pair_degeneracy_o (pair_degeneracy),
    .run_end_o         (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {4'b0000, pair_degeneracy, second_mode, first_mode};
  assign m_axis_tuser_o = kind;

endmodule

`default_nettype wire
